FILE: rtl/gdad_pkg.sv
`default_nettype none

package gdad_pkg;

  // field widths
  localparam int YearBits = 16;
  localparam int AddBits  = 12;
  // day accumulator holds the start day plus the full day count
  localparam int DayW     = AddBits + 1;
  localparam int CntW     = $clog2(YearBits);

  // gregorian leap cycle, year residue width
  localparam int                    ResW      = 9;
  localparam logic [ResW-1:0]       CycleLast = ResW'(399);
  localparam logic [ResW:0]         CycleLen  = (ResW+1)'(400);
  localparam logic [ResW-1:0]       Century1  = ResW'(100);
  localparam logic [ResW-1:0]       Century2  = ResW'(200);
  localparam logic [ResW-1:0]       Century3  = ResW'(300);

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  typedef struct packed {
    logic [4:0]          in_day;
    logic [3:0]          in_month;
    logic [YearBits-1:0] in_year;
    logic [AddBits-1:0]  add_days;
  } in_item_t;

  typedef struct packed {
    logic [4:0]          out_day;
    logic [3:0]          out_month;
    logic [YearBits-1:0] out_year;
    logic                valid_res;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StCheck,
    StWalk,
    StFinish
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic check;
    logic walk;
    logic out_write;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_busy;
  } dp_sts_t;

  // leap year from the year's residue modulo 400
  function automatic logic is_leap(input logic [ResW-1:0] res);
    logic quad;
    logic cent;
    quad = (res[1:0] == 2'b00);
    cent = (res == Century1) || (res == Century2) || (res == Century3);
    return (quad && !cent) || (res == '0);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MonthFeb:                                   len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gdad_ctrl.sv
`default_nettype none

module gdad_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire gdad_pkg::dp_sts_t sts_i,
  output gdad_pkg::dp_cmd_t      cmd_o
);
  import gdad_pkg::*;

  ctrl_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StMod;
          cnt_d   = CntW'(YearBits - 1);
        end
      end
      StMod: begin
        if (cnt_q == '0) begin
          state_d = StCheck;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StCheck: state_d = StWalk;
      StWalk: begin
        if (sts_i.walk_done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!sts_i.out_busy) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      StMod:    cmd_o.mod_step  = 1'b1;
      StCheck:  cmd_o.check     = 1'b1;
      StWalk:   cmd_o.walk      = !sts_i.walk_done;
      StFinish: cmd_o.out_write = !sts_i.out_busy;
      default:  cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/gdad_dp.sv
`default_nettype none

module gdad_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gdad_pkg::in_item_t in_data_i,
  input  wire gdad_pkg::dp_cmd_t  cmd_i,
  output gdad_pkg::dp_sts_t       sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output gdad_pkg::out_item_t     out_data_o
);
  import gdad_pkg::*;

  logic [DayW-1:0]     day_q, day_d;
  logic [3:0]          mon_q, mon_d;
  logic [YearBits:0]   year_q, year_d;
  logic [YearBits-1:0] shift_q, shift_d;
  logic [ResW-1:0]     res_q, res_d;
  logic [AddBits-1:0]  add_q;
  logic                bad_q, bad_d;
  out_item_t           out_q, out_d;
  logic                out_valid_q;

  logic [ResW:0]       rem_trial;
  logic [4:0]          cur_len;
  logic [DayW-1:0]     cur_len_ext;
  logic                date_ok;
  logic                over_len;

  assign cur_len     = month_len(mon_q, is_leap(res_q));
  assign cur_len_ext = DayW'(cur_len);
  assign over_len    = (day_q > cur_len_ext);
  assign rem_trial   = {res_q, shift_q[YearBits-1]};
  assign date_ok     = (mon_q >= MonthJan) && (mon_q <= MonthDec) &&
                       (day_q != '0) && !over_len;

  assign sts_o.walk_done = bad_q || !over_len;
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  always_comb begin
    day_d   = day_q;
    mon_d   = mon_q;
    year_d  = year_q;
    shift_d = shift_q;
    res_d   = res_q;
    bad_d   = bad_q;
    if (cmd_i.load) begin
      day_d   = DayW'(in_data_i.in_day);
      mon_d   = in_data_i.in_month;
      year_d  = {1'b0, in_data_i.in_year};
      shift_d = in_data_i.in_year;
      res_d   = '0;
      bad_d   = 1'b0;
    end else if (cmd_i.mod_step) begin
      // one restoring step of year mod 400, msb first
      shift_d = {shift_q[YearBits-2:0], 1'b0};
      if (rem_trial >= CycleLen) begin
        res_d = ResW'(rem_trial - CycleLen);
      end else begin
        res_d = rem_trial[ResW-1:0];
      end
    end else if (cmd_i.check) begin
      bad_d = !date_ok;
      day_d = day_q + DayW'(add_q);
    end else if (cmd_i.walk) begin
      day_d = day_q - cur_len_ext;
      if (mon_q == MonthDec) begin
        mon_d  = MonthJan;
        year_d = year_q + 1'b1;
        res_d  = (res_q == CycleLast) ? '0 : res_q + 1'b1;
      end else begin
        mon_d = mon_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (bad_q) begin
      out_d = '0;
    end else begin
      out_d.out_day   = day_q[4:0];
      out_d.out_month = mon_q;
      out_d.out_year  = year_q[YearBits-1:0];
      out_d.valid_res = !year_q[YearBits];
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    mon_q   <= mon_d;
    year_q  <= year_d;
    shift_q <= shift_d;
    res_q   <= res_d;
    if (cmd_i.load) begin
      add_q <= in_data_i.add_days;
    end
    if (cmd_i.out_write) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bad_q <= bad_d;
      if (cmd_i.out_write) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/gregorian_date_add_days.sv
`default_nettype none

// Gregorian date plus day count. An item carries a date (day, month, year) and a
// day count; the result item carries the date that many days later, or all
// zeros with valid_res low when the start date is not a real Gregorian date.
// valid_res is also low when the year runs past the year field; the day and
// month are then still correct and the year is wrapped. One item is worked on
// at a time: the year is first reduced modulo 400 bit by bit for the leap rule,
// a check step then checks the date and adds the count, and the walk consumes
// one month per cycle until the day fits its month. Years are 16 bits and the
// day count reaches at most 4095. The result sits in an output register, so
// the next item is accepted while a finished result still waits to be taken.

module gregorian_date_add_days (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input items
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire gdad_pkg::in_item_t  in_data_i,
  // result items
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output gdad_pkg::out_item_t      out_data_o
);
  import gdad_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer: year reduction, date check, month walk, result hand-off
  gdad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // datapath: date registers, mod-400 residue, output register
  gdad_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
